/* design/ccm_pkg.sv */
// Shared types, register codes and reset values of the coverage count colour map.
package ccm_pkg;

  // Image size default and palette cap.
  localparam int PIXEL_COUNT_DEFAULT = 65536;
  localparam int PALETTE_CAP         = 10;
  localparam int PALETTE_ENTRIES     = 11;
  localparam int PAIR_REGS           = 5;

  // Configuration port geometry: 64-bit data, registers eight bytes apart.
  localparam int CFG_AW      = 6;
  localparam int CFG_DW      = 64;
  localparam int REG_SEL_LSB = 3;

  // Transaction kinds.
  localparam logic KIND_ACCUMULATE = 1'b0;
  localparam logic KIND_READOUT    = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_COLOURS_0_1     = 3'd0,
    REG_COLOURS_2_3     = 3'd1,
    REG_COLOURS_4_5     = 3'd2,
    REG_COLOURS_6_7     = 3'd3,
    REG_COLOURS_8_9     = 3'd4,
    REG_COLOUR_TEN_PLUS = 3'd5,
    REG_GREY_MAP        = 3'd6
  } reg_index_t;

  // Register reset values.
  localparam logic [47:0] COLOURS_0_1_RESET     = 48'h0000FF000000;
  localparam logic [47:0] COLOURS_2_3_RESET     = 48'hFF0000FFFF00;
  localparam logic [47:0] COLOURS_PAIR_RESET    = 48'hFF0000FF0000;
  localparam logic [23:0] COLOUR_TEN_PLUS_RESET = 24'hFF0000;
  localparam logic [16:0] GREY_MAP_RESET        = 17'h0FF00;

  // Input transaction.
  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_index;
    logic [7:0]  grey;
  } item_t;

  // Output transaction.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  // One pixel's stored state.
  typedef struct packed {
    logic [7:0] count;
    logic [7:0] mean;
  } entry_t;

  // Decoded colour map settings handed from the register file to the pipeline.
  typedef struct packed {
    logic [PALETTE_ENTRIES-1:0][23:0] palette;
    logic [7:0]                       low;
    logic [7:0]                       high;
    logic                             binary;
  } map_cfg_t;

endpackage

/* design/ccm_regs.sv */
// Configuration register file with its bus port and the decoded colour map settings.
module ccm_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccm_pkg::CFG_AW-1:0] paddr,
  input  logic [ccm_pkg::CFG_DW-1:0] pwdata,
  output logic [ccm_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output ccm_pkg::map_cfg_t          map_cfg
);
  import ccm_pkg::*;

  logic [47:0] pair [PAIR_REGS];
  logic [23:0] ten_plus;
  logic [16:0] grey_map;
  reg_index_t  sel;
  logic        wr_stb;

  assign pready = 1'b1;
  assign sel    = reg_index_t'(paddr[CFG_AW-1:REG_SEL_LSB]);
  assign wr_stb = psel && penable && pwrite;

  // Register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair[0]  <= COLOURS_0_1_RESET;
      pair[1]  <= COLOURS_2_3_RESET;
      pair[2]  <= COLOURS_PAIR_RESET;
      pair[3]  <= COLOURS_PAIR_RESET;
      pair[4]  <= COLOURS_PAIR_RESET;
      ten_plus <= COLOUR_TEN_PLUS_RESET;
      grey_map <= GREY_MAP_RESET;
    end else if (wr_stb) begin
      unique case (sel)
        REG_COLOURS_0_1:     pair[0]  <= pwdata[47:0];
        REG_COLOURS_2_3:     pair[1]  <= pwdata[47:0];
        REG_COLOURS_4_5:     pair[2]  <= pwdata[47:0];
        REG_COLOURS_6_7:     pair[3]  <= pwdata[47:0];
        REG_COLOURS_8_9:     pair[4]  <= pwdata[47:0];
        REG_COLOUR_TEN_PLUS: ten_plus <= pwdata[23:0];
        REG_GREY_MAP:        grey_map <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (sel)
      REG_COLOURS_0_1:     prdata = CFG_DW'(pair[0]);
      REG_COLOURS_2_3:     prdata = CFG_DW'(pair[1]);
      REG_COLOURS_4_5:     prdata = CFG_DW'(pair[2]);
      REG_COLOURS_6_7:     prdata = CFG_DW'(pair[3]);
      REG_COLOURS_8_9:     prdata = CFG_DW'(pair[4]);
      REG_COLOUR_TEN_PLUS: prdata = CFG_DW'(ten_plus);
      REG_GREY_MAP:        prdata = CFG_DW'(grey_map);
      default:             prdata = '0;
    endcase
  end

  // Unpack the palette and clamp the grey bounds.
  always_comb begin
    for (int i = 0; i < PAIR_REGS; i++) begin
      map_cfg.palette[2*i]   = pair[i][23:0];
      map_cfg.palette[2*i+1] = pair[i][47:24];
    end
    map_cfg.palette[PALETTE_ENTRIES-1] = ten_plus;
    map_cfg.low    = (grey_map[7:0] > 8'd254) ? 8'd254 : grey_map[7:0];
    map_cfg.high   = (grey_map[15:8] == 8'd0) ? 8'd1 : grey_map[15:8];
    map_cfg.binary = grey_map[16];
  end

endmodule

/* design/ccm_store.sv */
// Per-pixel count and mean memory with its clearing pass after reset.
module ccm_store #(
  parameter  int PIXEL_COUNT = ccm_pkg::PIXEL_COUNT_DEFAULT,
  localparam int AW          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  output logic             clearing,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output ccm_pkg::entry_t  rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  ccm_pkg::entry_t  wr_data
);
  import ccm_pkg::*;

  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_COUNT - 1);

  entry_t          mem [PIXEL_COUNT];
  logic [AW-1:0]   clear_addr;

  // Sweep every entry once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  // Single write port; the sweep owns it while it runs.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clear_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/ccm_pipe.sv */
// Six-stage pipeline: read, mean update by restoring division, colour mapping, output.
module ccm_pipe #(
  parameter  int PIXEL_COUNT = ccm_pkg::PIXEL_COUNT_DEFAULT,
  localparam int AW          = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  ccm_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_stall,
  output ccm_pkg::result_t   result,
  input  ccm_pkg::map_cfg_t  map_cfg,
  input  logic               clearing,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  ccm_pkg::entry_t    rd_data,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output ccm_pkg::entry_t    wr_data
);
  import ccm_pkg::*;

  // floor(x/255) for 16-bit x is (x*32897) >> 23.
  localparam logic [15:0] RECIP_255 = 16'd32897;
  localparam int          PAD_W     = 25;

  typedef struct packed {
    logic [8:0] rem;
    logic       q;
  } div_step_t;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(RECIP_255);
    return p[30:23];
  endfunction

  // One restoring division step; the remainder always stays below the divisor.
  function automatic div_step_t div_step(input logic [8:0] rem, input logic nbit,
                                         input logic [8:0] d);
    logic [9:0] t;
    div_step_t  r;
    t = {rem, nbit};
    if (t >= {1'b0, d}) begin
      r.rem = 9'(t - {1'b0, d});
      r.q   = 1'b1;
    end else begin
      r.rem = t[8:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [15:0] idx);
    logic [PAD_W-1:0] w;
    w = PAD_W'(idx);
    return w[AW-1:0];
  endfunction

  // Stage control.
  logic [6:1]  vld, rdy, ro, wr;
  logic [15:0] idx [1:6];
  logic        hit, accept, in_range;

  // Stage 1.
  logic [7:0]  grey1;
  logic        rng1;
  logic [7:0]  cnt_e, mean_e, mean_r;
  logic [3:0]  entry;
  logic [23:0] colour;
  logic [15:0] num_n;
  logic [2:0][15:0] x_n;

  // Stage 2.
  logic [15:0] num2;
  logic [7:0]  cnt2;
  logic [2:0][15:0] x2;
  logic [8:0]  d2;
  div_step_t   s2a, s2b;
  logic [2:0][7:0] c_n;

  // Stage 3.
  logic [8:0]  rem3, d3;
  logic [1:0]  q3;
  logic [5:0]  lo3;
  logic [7:0]  cnt3;
  logic [2:0][7:0] c3;
  div_step_t   s3a, s3b;
  logic [2:0][15:0] y_n;

  // Stage 4.
  logic [8:0]  rem4, d4;
  logic [3:0]  q4;
  logic [3:0]  lo4;
  logic [7:0]  cnt4;
  logic [2:0][15:0] y4;
  div_step_t   s4a, s4b;
  logic [2:0][7:0] z_n;

  // Stage 5.
  logic [8:0]  rem5, d5;
  logic [5:0]  q5;
  logic [1:0]  lo5;
  logic [7:0]  cnt5;
  logic [2:0][7:0] z5;
  div_step_t   s5a, s5b;

  // Stage 6, which is also the output register.
  logic [7:0]  mean6, cnt6;
  result_t     rgb6;

  // Each stage takes a new transaction when it is empty or its own one moves on.
  // An accumulate in the last stage always leaves, as it has no result.
  always_comb begin
    rdy[6] = !vld[6] || (ro[6] != KIND_READOUT) || !result_stall;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  // Hold a transaction whose pixel has a write still in flight.
  always_comb begin
    hit = 1'b0;
    for (int k = 1; k <= 6; k++) begin
      hit = hit | (vld[k] && wr[k] && (idx[k] == item.pixel_index));
    end
  end

  assign in_range   = 32'(item.pixel_index) < 32'(PIXEL_COUNT);
  assign item_stall = clearing || !rdy[1] || hit;
  assign accept     = item_valid && !item_stall;
  assign rd_en      = accept;
  assign rd_addr    = to_addr(item.pixel_index);

  // Stage 1 to 2: product for the running mean, palette lookup and mean times colour.
  always_comb begin
    cnt_e  = rng1 ? rd_data.count : 8'd0;
    mean_e = rng1 ? rd_data.mean : 8'd0;
    num_n  = 16'(mean_e) * 16'(cnt_e) + 16'(grey1);
    if (map_cfg.binary) begin
      mean_r = (cnt_e == 8'd0) ? 8'd0 : 8'd255;
    end else begin
      mean_r = mean_e;
    end
    entry  = (cnt_e < 8'(PALETTE_CAP)) ? 4'(cnt_e) : 4'(PALETTE_CAP);
    colour = map_cfg.palette[entry];
    for (int ch = 0; ch < 3; ch++) begin
      x_n[ch] = 16'(mean_r) * 16'(colour[8*(2-ch) +: 8]);
    end
  end

  // Stage 2 to 3: first two quotient bits, and the colour scaled by the mean.
  always_comb begin
    d2  = 9'(cnt2) + 9'd1;
    s2a = div_step({1'b0, num2[15:8]}, num2[7], d2);
    s2b = div_step(s2a.rem, num2[6], d2);
    for (int ch = 0; ch < 3; ch++) begin
      c_n[ch] = div255(x2[ch]);
    end
  end

  // Stage 3 to 4: next two quotient bits, and the blend between the grey bounds.
  always_comb begin
    s3a = div_step(rem3, lo3[5], d3);
    s3b = div_step(s3a.rem, lo3[4], d3);
    for (int ch = 0; ch < 3; ch++) begin
      y_n[ch] = 16'(map_cfg.low) * 16'(8'd255 - c3[ch]) + 16'(map_cfg.high) * 16'(c3[ch]);
    end
  end

  // Stage 4 to 5: next two quotient bits, and the blend divided by 255.
  always_comb begin
    s4a = div_step(rem4, lo4[3], d4);
    s4b = div_step(s4a.rem, lo4[2], d4);
    for (int ch = 0; ch < 3; ch++) begin
      z_n[ch] = div255(y4[ch]);
    end
  end

  // Stage 5 to 6: last two quotient bits.
  always_comb begin
    s5a = div_step(rem5, lo5[1], d5);
    s5b = div_step(s5a.rem, lo5[0], d5);
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= accept;
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (accept) begin
      ro[1]  <= (item.kind == KIND_READOUT);
      wr[1]  <= (item.kind == KIND_ACCUMULATE) && (item.grey != 8'd0) && in_range;
      idx[1] <= item.pixel_index;
      grey1  <= item.grey;
      rng1   <= in_range;
    end
    if (rdy[2] && vld[1]) begin
      ro[2]  <= ro[1];
      wr[2]  <= wr[1];
      idx[2] <= idx[1];
      num2   <= num_n;
      cnt2   <= cnt_e;
      x2     <= x_n;
    end
    if (rdy[3] && vld[2]) begin
      ro[3]  <= ro[2];
      wr[3]  <= wr[2];
      idx[3] <= idx[2];
      rem3   <= s2b.rem;
      q3     <= {s2a.q, s2b.q};
      lo3    <= num2[5:0];
      d3     <= d2;
      cnt3   <= cnt2;
      c3     <= c_n;
    end
    if (rdy[4] && vld[3]) begin
      ro[4]  <= ro[3];
      wr[4]  <= wr[3];
      idx[4] <= idx[3];
      rem4   <= s3b.rem;
      q4     <= {q3, s3a.q, s3b.q};
      lo4    <= lo3[3:0];
      d4     <= d3;
      cnt4   <= cnt3;
      y4     <= y_n;
    end
    if (rdy[5] && vld[4]) begin
      ro[5]  <= ro[4];
      wr[5]  <= wr[4];
      idx[5] <= idx[4];
      rem5   <= s4b.rem;
      q5     <= {q4, s4a.q, s4b.q};
      lo5    <= lo4[1:0];
      d5     <= d4;
      cnt5   <= cnt4;
      z5     <= z_n;
    end
    if (rdy[6] && vld[5]) begin
      ro[6]      <= ro[5];
      wr[6]      <= wr[5];
      idx[6]     <= idx[5];
      mean6      <= {q5, s5a.q, s5b.q};
      cnt6       <= (cnt5 == 8'd255) ? cnt5 : cnt5 + 8'd1;
      rgb6.red   <= z5[0];
      rgb6.green <= z5[1];
      rgb6.blue  <= z5[2];
    end
  end

  // Write back the updated pixel as the accumulate leaves the last stage.
  assign wr_en         = vld[6] && wr[6];
  assign wr_addr       = to_addr(idx[6]);
  assign wr_data.count = cnt6;
  assign wr_data.mean  = mean6;

  assign result_valid = vld[6] && (ro[6] == KIND_READOUT);
  assign result       = rgb6;

endmodule

/* design/coverage_count_colour_map.sv */
// Coverage count colour map: top level joining registers, pixel store and pipeline.
//
// Input transactions (item) either fold a grey value into a pixel's coverage count
// and running mean, or read a pixel out as an RGB colour. Only readouts produce an
// output transaction (result). Both channels use valid and stall.
// A readout's result is shown once it reaches stage 6, the output register, and
// stays there while stalled. One transaction enters per cycle while item_stall is low.
// A transaction whose pixel has an accumulate still in the six pipeline stages is
// held until that write has gone to memory, later when a stalled readout is ahead of
// it; the read-modify-write loop through the pixel memory sets this.
// After reset a clearing pass zeroes every one of the PIXEL_COUNT pixels (65536 by
// default), one per cycle; item_stall stays high until it ends. Register writes
// are taken at any time but must only change settings while the block is idle.
// When the receiver stalls, the output register holds its result and the stages
// behind it keep filling; accumulates keep draining until a readout blocks them.
module coverage_count_colour_map #(
  parameter int PIXEL_COUNT = ccm_pkg::PIXEL_COUNT_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  ccm_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output ccm_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ccm_pkg::CFG_AW-1:0] paddr,
  input  logic [ccm_pkg::CFG_DW-1:0] pwdata,
  output logic [ccm_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import ccm_pkg::*;

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  map_cfg_t      map_cfg;
  logic          clearing;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;

  // Configuration registers.
  ccm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .map_cfg (map_cfg)
  );

  // Pixel count and mean memory.
  ccm_store #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // Processing pipeline.
  ccm_pipe #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_pipe (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .map_cfg      (map_cfg),
    .clearing     (clearing),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

endmodule

/* design/ccm_checker.sv */
// Port-level checks for the coverage count colour map, bound to its top level.
module ccm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_stall,
  input logic                       result_valid,
  input logic                       result_stall,
  input ccm_pkg::result_t           result,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [ccm_pkg::CFG_AW-1:0] paddr,
  input logic [ccm_pkg::CFG_DW-1:0] pwdata,
  input logic [ccm_pkg::CFG_DW-1:0] prdata
);
  import ccm_pkg::*;

  // A stalled result transaction stays and keeps its value.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // The clearing pass blocks input right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> item_stall)
    else $error("input taken during the clearing pass");

  // Reset empties the pipeline.
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result present after reset");

  // The grey map register reads back what was last written.
  a_grey_map_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && (paddr[CFG_AW-1:REG_SEL_LSB] == REG_GREY_MAP))
    ##1 (psel && !pwrite && (paddr[CFG_AW-1:REG_SEL_LSB] == REG_GREY_MAP))
    |-> prdata == CFG_DW'($past(pwdata[16:0])))
    else $error("grey map read back differs from the write");

endmodule

bind coverage_count_colour_map ccm_checker u_ccm_checker (.*);
